>>> rtl/core/spwq_pkg.sv
`default_nettype none

package spwq_pkg;

  typedef enum logic [1:0] {
    ST_INSERTED = 2'd0,
    ST_POPPED   = 2'd1,
    ST_EMPTY    = 2'd2,
    ST_FULL     = 2'd3
  } status_e;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_POP    = 1'b1;

  localparam int unsigned TAG_W  = 16;
  localparam int unsigned PRIO_W = 8;
  localparam int unsigned OCC_W  = 5;

  typedef struct packed {
    logic              opcode;
    logic [TAG_W-1:0]  passenger_tag;
    logic [PRIO_W-1:0] priority_req;
  } in_t;

  typedef struct packed {
    status_e           status;
    logic [TAG_W-1:0]  out_tag;
    logic [PRIO_W-1:0] out_priority;
    logic [OCC_W-1:0]  occupancy;
  } out_t;

  // decoded request handed from the front queue to the sorted list
  typedef struct packed {
    logic              is_pop;
    logic [TAG_W-1:0]  tag;
    logic [PRIO_W-1:0] prio;
  } cmd_t;

endpackage

`default_nettype wire

>>> rtl/core/spwq_front.sv
`default_nettype none

module spwq_front (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          push,
  output logic               full,
  input  wire spwq_pkg::in_t req,
  output logic               cmd_valid,
  input  wire logic          cmd_ready,
  output spwq_pkg::cmd_t     cmd
);

  spwq_pkg::cmd_t slot [2];
  logic           wp;
  logic           rp;
  logic [1:0]     cnt;
  logic           push_fire;
  logic           take_fire;
  spwq_pkg::cmd_t dec;

  always_comb begin
    dec.is_pop = (req.opcode == spwq_pkg::OP_POP);
    dec.tag    = req.passenger_tag;
    dec.prio   = req.priority_req;
  end

  assign full      = (cnt == 2'd2);
  assign cmd_valid = (cnt != 2'd0);
  assign cmd       = slot[rp];
  assign push_fire = push && !full;
  assign take_fire = cmd_valid && cmd_ready;

  always_ff @(posedge clk) begin
    if (push_fire) begin
      slot[wp] <= dec;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= 1'b0;
      rp  <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (push_fire) begin
        wp <= !wp;
      end
      if (take_fire) begin
        rp <= !rp;
      end
      cnt <= cnt + 2'(push_fire) - 2'(take_fire);
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (rst) cnt <= 2'd2)
    else $error("front queue count overflow");
  a_take_order: assert property (@(posedge clk) disable iff (rst)
    take_fire && !push_fire |=> cnt == $past(cnt) - 2'd1)
    else $error("front queue count lost a take");
  a_ptr_gap: assert property (@(posedge clk) disable iff (rst)
    (cnt == 2'd0 || cnt == 2'd2) |-> wp == rp)
    else $error("front queue pointers disagree with count");

endmodule

`default_nettype wire

>>> rtl/core/spwq_back.sv
`default_nettype none

module spwq_back #(
  parameter int unsigned CAPACITY      = 16,
  parameter int unsigned TAG_BITS      = 16,
  parameter int unsigned PRIORITY_BITS = 8
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           cmd_valid,
  output logic                cmd_ready,
  input  wire spwq_pkg::cmd_t cmd,
  output logic                empty,
  input  wire logic           pop,
  output spwq_pkg::out_t      rsp
);

  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned TW = (TAG_BITS > spwq_pkg::TAG_W) ? TAG_BITS : spwq_pkg::TAG_W;
  localparam int unsigned PW = (PRIORITY_BITS > spwq_pkg::PRIO_W) ?
                               PRIORITY_BITS : spwq_pkg::PRIO_W;
  localparam int unsigned OW = (CW > spwq_pkg::OCC_W) ? CW : spwq_pkg::OCC_W;

  logic [TAG_BITS-1:0]      tags  [CAPACITY];
  logic [PRIORITY_BITS-1:0] prios [CAPACITY];
  logic [CW-1:0]            cnt;
  logic [CW-1:0]            cnt_next;

  logic [TW-1:0]            tag_in_w;
  logic [PW-1:0]            prio_in_w;
  logic [TAG_BITS-1:0]      tag_in;
  logic [PRIORITY_BITS-1:0] prio_in;
  logic [TW-1:0]            head_tag_w;
  logic [PW-1:0]            head_prio_w;
  logic [OW-1:0]            occ_w;

  logic [CAPACITY-1:0]      ge;
  logic                     issue;
  logic                     is_full;
  logic                     is_empty;
  logic                     do_ins;
  logic                     do_pop;
  spwq_pkg::out_t           res;

  spwq_pkg::out_t           rq [2];
  logic                     wp;
  logic                     rp;
  logic [1:0]               rc;
  logic                     pop_fire;

  assign tag_in_w  = TW'(cmd.tag);
  assign prio_in_w = PW'(cmd.prio);
  assign tag_in    = tag_in_w[TAG_BITS-1:0];
  assign prio_in   = prio_in_w[PRIORITY_BITS-1:0];

  assign pop_fire  = pop && !empty;
  assign empty     = (rc == 2'd0);
  assign rsp       = rq[rp];
  assign cmd_ready = (rc != 2'd2) || pop_fire;
  assign issue     = cmd_valid && cmd_ready;

  assign is_full  = (cnt == CW'(CAPACITY));
  assign is_empty = (cnt == '0);
  assign do_ins   = issue && !cmd.is_pop && !is_full;
  assign do_pop   = issue && cmd.is_pop && !is_empty;

  // empty slots count as "greater", so the new entry lands after every stored
  // entry of equal or lower priority
  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      ge[i] = (CW'(i) >= cnt) || (prios[i] > prio_in);
    end
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    always_ff @(posedge clk) begin
      if (do_ins && ge[i]) begin
        if (i > 0 && ge[(i > 0) ? i - 1 : 0]) begin
          tags[i]  <= tags[(i > 0) ? i - 1 : 0];
          prios[i] <= prios[(i > 0) ? i - 1 : 0];
        end else begin
          tags[i]  <= tag_in;
          prios[i] <= prio_in;
        end
      end else if (do_pop && (i < CAPACITY - 1)) begin
        tags[i]  <= tags[(i < CAPACITY - 1) ? i + 1 : i];
        prios[i] <= prios[(i < CAPACITY - 1) ? i + 1 : i];
      end
    end
  end

  always_comb begin
    cnt_next = cnt;
    if (do_ins) begin
      cnt_next = cnt + CW'(1);
    end else if (do_pop) begin
      cnt_next = cnt - CW'(1);
    end
  end

  assign head_tag_w  = TW'(tags[0]);
  assign head_prio_w = PW'(prios[0]);
  assign occ_w       = OW'(cnt_next);

  always_comb begin
    res.out_tag      = '0;
    res.out_priority = '0;
    res.occupancy    = occ_w[spwq_pkg::OCC_W-1:0];
    if (cmd.is_pop) begin
      if (is_empty) begin
        res.status = spwq_pkg::ST_EMPTY;
      end else begin
        res.status       = spwq_pkg::ST_POPPED;
        res.out_tag      = head_tag_w[spwq_pkg::TAG_W-1:0];
        res.out_priority = head_prio_w[spwq_pkg::PRIO_W-1:0];
      end
    end else if (is_full) begin
      res.status = spwq_pkg::ST_FULL;
    end else begin
      res.status = spwq_pkg::ST_INSERTED;
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      rq[wp] <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
      wp  <= 1'b0;
      rp  <= 1'b0;
      rc  <= 2'd0;
    end else begin
      cnt <= cnt_next;
      if (issue) begin
        wp <= !wp;
      end
      if (pop_fire) begin
        rp <= !rp;
      end
      rc <= rc + 2'(issue) - 2'(pop_fire);
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    cnt <= CW'(CAPACITY))
    else $error("entry count beyond capacity");
  a_head_sorted: assert property (@(posedge clk) disable iff (rst)
    cnt >= CW'(2) |-> prios[0] <= prios[1])
    else $error("head entries out of priority order");
  a_full_drop: assert property (@(posedge clk) disable iff (rst)
    issue && !cmd.is_pop && is_full |=> cnt == CW'(CAPACITY))
    else $error("insert into full list changed the count");
  a_rq_bound: assert property (@(posedge clk) disable iff (rst) rc <= 2'd2)
    else $error("result queue overflow");

endmodule

`default_nettype wire

>>> rtl/core/stable_priority_waitlist_queue.sv
`default_nettype none

// Sorted waitlist of up to CAPACITY entries (tag, priority), lowest priority
// first, equal priorities in arrival order. A request (opcode 0 insert,
// 1 pop) is taken on push && !full and yields exactly one result, shown while
// empty is low and taken on pop. Requests pass through a two-entry front
// queue into a shift-register list whose cells compare against the new
// priority in parallel, so one request is executed per cycle while the
// result queue has room or is popped; a result is visible once registered
// there. When results are not popped, two results wait, then two more
// requests queue in front before full rises. Pop on an empty list reports
// status 2; insert into a full list is dropped with status 3.
module stable_priority_waitlist_queue #(
  parameter int unsigned CAPACITY      = 16,
  parameter int unsigned TAG_BITS      = 16,
  parameter int unsigned PRIORITY_BITS = 8
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          push,
  output logic               full,
  input  wire spwq_pkg::in_t req,
  output logic               empty,
  input  wire logic          pop,
  output spwq_pkg::out_t     rsp
);

  logic           cmd_valid;
  logic           cmd_ready;
  spwq_pkg::cmd_t cmd;

  spwq_front u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .req       (req),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd)
  );

  spwq_back #(
    .CAPACITY      (CAPACITY),
    .TAG_BITS      (TAG_BITS),
    .PRIORITY_BITS (PRIORITY_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd),
    .empty     (empty),
    .pop       (pop),
    .rsp       (rsp)
  );

endmodule

`default_nettype wire

>>> test/stable_priority_waitlist_queue_checker.sv
`default_nettype none

module stable_priority_waitlist_queue_checker #(
  parameter int unsigned CAPACITY = 16
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           push,
  input  wire logic           full,
  input  wire spwq_pkg::in_t  request,
  input  wire logic           empty,
  input  wire logic           pop,
  input  wire spwq_pkg::out_t result,
  output int unsigned         mismatches,
  output int unsigned         outstanding
);

  logic [spwq_pkg::TAG_W-1:0]  held_tag  [CAPACITY];
  logic [spwq_pkg::PRIO_W-1:0] held_prio [CAPACITY];
  int unsigned                 held_count;
  spwq_pkg::out_t              expected_q [$];
  int unsigned                 fail_count;

  // Sorted list model: head at slot 0, ties keep arrival order.
  function automatic spwq_pkg::out_t serve_request(spwq_pkg::in_t r);
    spwq_pkg::out_t o;
    int unsigned    slot;
    int unsigned    k;
    o = '0;
    if (r.opcode == spwq_pkg::OP_INSERT) begin
      if (held_count >= CAPACITY) begin
        o.status = spwq_pkg::ST_FULL;
      end else begin
        slot = 0;
        while (slot < held_count && held_prio[slot] <= r.priority_req) slot++;
        for (k = held_count; k > slot; k--) begin
          held_tag[k]  = held_tag[k-1];
          held_prio[k] = held_prio[k-1];
        end
        held_tag[slot]  = r.passenger_tag;
        held_prio[slot] = r.priority_req;
        held_count++;
        o.status = spwq_pkg::ST_INSERTED;
      end
    end else if (held_count == 0) begin
      o.status = spwq_pkg::ST_EMPTY;
    end else begin
      o.status       = spwq_pkg::ST_POPPED;
      o.out_tag      = held_tag[0];
      o.out_priority = held_prio[0];
      for (k = 1; k < held_count; k++) begin
        held_tag[k-1]  = held_tag[k];
        held_prio[k-1] = held_prio[k];
      end
      held_count--;
    end
    o.occupancy = spwq_pkg::OCC_W'(held_count);
    return o;
  endfunction

  function automatic void log_failure(spwq_pkg::out_t want, spwq_pkg::out_t got,
                                      bit unexpected);
    fail_count++;
    if (fail_count <= 10) begin
      if (unexpected)
        $display("%0t: result with no request pending: status %0d tag %h prio %h occ %0d",
                 $realtime, got.status, got.out_tag, got.out_priority, got.occupancy);
      else
        $display({"%0t: result mismatch: expected status %0d tag %h prio %h occ %0d,",
                  " got status %0d tag %h prio %h occ %0d"},
                 $realtime, want.status, want.out_tag, want.out_priority, want.occupancy,
                 got.status, got.out_tag, got.out_priority, got.occupancy);
    end
  endfunction

  always @(posedge clk) begin : watch
    spwq_pkg::out_t want;
    if (rst) begin
      held_count = 0;
      fail_count = 0;
      expected_q.delete();
    end else begin
      if (pop === 1'b1 && empty === 1'b0) begin
        if (expected_q.size() == 0) begin
          log_failure('0, result, 1'b1);
        end else begin
          want = expected_q.pop_front();
          if (result.status !== want.status || result.out_tag !== want.out_tag ||
              result.out_priority !== want.out_priority ||
              result.occupancy !== want.occupancy)
            log_failure(want, result, 1'b0);
        end
      end
      if (push === 1'b1 && full === 1'b0)
        expected_q.push_back(serve_request(request));
    end
    mismatches  <= fail_count;
    outstanding <= expected_q.size();
  end

endmodule

`default_nettype wire

>>> test/stable_priority_waitlist_queue_test.sv
`default_nettype none

module stable_priority_waitlist_queue_test;

  localparam int unsigned DEPTH        = 16;
  localparam int unsigned RANDOM_ITEMS = 1730;
  localparam int unsigned TAIL_ITEMS   = 250;
  localparam int unsigned PAUSE_AT     = 800;
  localparam int unsigned CYCLE_LIMIT  = 400000;

  logic           clk;
  logic           rst     = 1'b1;
  logic           push    = 1'b0;
  logic           pop     = 1'b0;
  spwq_pkg::in_t  request = '0;
  logic           full;
  logic           empty;
  spwq_pkg::out_t result;
  int unsigned    mismatches;
  int unsigned    outstanding;
  bit             quiet_tail = 1'b0;
  int unsigned    cycle_count;

  stable_priority_waitlist_queue #(.CAPACITY(DEPTH)) u_dut (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .full  (full),
    .req   (request),
    .empty (empty),
    .pop   (pop),
    .rsp   (result)
  );

  stable_priority_waitlist_queue_checker #(.CAPACITY(DEPTH)) u_checker (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .full        (full),
    .request     (request),
    .empty       (empty),
    .pop         (pop),
    .result      (result),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("** stable_priority_waitlist_queue: FAILED **");
    $finish;
  end

  function automatic spwq_pkg::in_t make_request(logic op,
                                                 logic [spwq_pkg::TAG_W-1:0] tag,
                                                 logic [spwq_pkg::PRIO_W-1:0] prio);
    spwq_pkg::in_t r;
    r.opcode        = op;
    r.passenger_tag = tag;
    r.priority_req  = prio;
    return r;
  endfunction

  // narrow priority bands give plenty of ties
  function automatic spwq_pkg::in_t random_request(int unsigned insert_pct);
    spwq_pkg::in_t r;
    r.opcode        = ($urandom_range(0, 99) < insert_pct) ? spwq_pkg::OP_INSERT :
                                                             spwq_pkg::OP_POP;
    r.passenger_tag = spwq_pkg::TAG_W'($urandom);
    case ($urandom_range(0, 3))
      0:       r.priority_req = spwq_pkg::PRIO_W'($urandom_range(0, 3));
      1:       r.priority_req = spwq_pkg::PRIO_W'(255 - $urandom_range(0, 3));
      default: r.priority_req = spwq_pkg::PRIO_W'($urandom);
    endcase
    return r;
  endfunction

  task automatic send_request(spwq_pkg::in_t r);
    push    <= 1'b1;
    request <= r;
    do @(posedge clk); while (full !== 1'b0);
  endtask

  task automatic pace_sender(int unsigned gap_pct);
    if (!quiet_tail && $urandom_range(0, 99) < gap_pct) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
  endtask

  initial begin : drain_side
    int unsigned stall_pct;
    int unsigned beat;
    stall_pct = 0;
    beat      = 0;
    forever begin
      if (beat % 64 == 0) begin
        case ($urandom_range(0, 2))
          0:       stall_pct = 0;
          1:       stall_pct = 10;
          default: stall_pct = 40;
        endcase
      end
      beat++;
      if (!quiet_tail && $urandom_range(0, 99) < stall_pct) begin
        pop <= 1'b0;
        repeat ($urandom_range(1, 18)) @(posedge clk);
      end else begin
        pop <= 1'b1;
        @(posedge clk);
      end
    end
  end

  initial begin : feed_side
    int unsigned insert_pct;
    int unsigned gap_pct;
    int unsigned n;
    insert_pct = 50;
    gap_pct    = 20;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // pop on empty, tag/priority extremes, ties, fill past capacity, drain a few
    send_request(make_request(spwq_pkg::OP_POP, 16'h0000, 8'h00));
    pace_sender(gap_pct);
    send_request(make_request(spwq_pkg::OP_INSERT, 16'hffff, 8'hff));
    send_request(make_request(spwq_pkg::OP_INSERT, 16'h0000, 8'h00));
    pace_sender(gap_pct);
    send_request(make_request(spwq_pkg::OP_INSERT, 16'h0001, 8'h00));
    send_request(make_request(spwq_pkg::OP_INSERT, 16'ha5a5, 8'h80));
    send_request(make_request(spwq_pkg::OP_INSERT, 16'h5a5a, 8'h80));
    for (n = 0; n < 11; n++) begin
      send_request(make_request(spwq_pkg::OP_INSERT, spwq_pkg::TAG_W'(16'h1000 + n),
                                spwq_pkg::PRIO_W'(8'h7f + n % 3)));
      pace_sender(gap_pct);
    end
    send_request(make_request(spwq_pkg::OP_INSERT, 16'hbeef, 8'h00));
    repeat (4) begin
      send_request(make_request(spwq_pkg::OP_POP, 16'hffff, 8'hff));
      pace_sender(gap_pct);
    end

    for (n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 40 == 0) begin
        case ($urandom_range(0, 2))
          0:       insert_pct = 85;
          1:       insert_pct = 50;
          default: insert_pct = 15;
        endcase
        case ($urandom_range(0, 2))
          0:       gap_pct = 0;
          1:       gap_pct = 15;
          default: gap_pct = 40;
        endcase
      end
      if (n == RANDOM_ITEMS - TAIL_ITEMS) quiet_tail = 1'b1;
      if (n == PAUSE_AT) begin
        push <= 1'b0;
        do @(posedge clk); while (outstanding != 0);
      end
      send_request(random_request(insert_pct));
      pace_sender(gap_pct);
    end

    push <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (10) @(posedge clk);
    if (mismatches == 0)
      $display("** stable_priority_waitlist_queue: PASSED **");
    else
      $display("** stable_priority_waitlist_queue: FAILED **");
    $finish;
  end

endmodule

`default_nettype wire
